// ----- rtl/core/x86_64_instruction_length_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the instruction length decoder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef X86_64_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH
`define X86_64_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH

// Check a property at every rising edge outside reset
`define X64ILD_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset
`define X64ILD_ASSERT_NEVER(name, cond, msg) \
  `X64ILD_ASSERT_CLK(name, !(cond), msg)

`endif

// ----- rtl/core/x64ild_pkg.sv -----
// ----------------------------------------------------------------------------
// x64ild_pkg
// Shared types and constants of the x86-64 instruction length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package x64ild_pkg;

  // Opcode form flags
  typedef logic [8:0] form_t;

  localparam form_t FormNone  = 9'h001;
  localparam form_t FormModrm = 9'h002;
  localparam form_t FormImm8  = 9'h004;
  localparam form_t FormImm16 = 9'h008;
  localparam form_t FormImmz  = 9'h010;
  localparam form_t FormImm64 = 9'h020;
  localparam form_t FormRel8  = 9'h040;
  localparam form_t FormRel32 = 9'h080;
  localparam form_t FormMoffs = 9'h100;

  // Bytes with a fixed meaning
  localparam logic [7:0] ByteEscape = 8'h0F;
  localparam logic [7:0] ByteOpsize = 8'h66;
  localparam logic [7:0] ByteGrp3B  = 8'hF6;
  localparam logic [7:0] ByteGrp3V  = 8'hF7;
  localparam logic [3:0] RexHigh    = 4'h4;
  localparam logic [4:0] MaxLength  = 5'd15;

  // Result status codes
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnknown   = 2'd1,
    StTruncated = 2'd2,
    StTooLong   = 2'd3
  } status_e;

  // Forms of one byte in both opcode maps
  typedef struct packed {
    form_t one_byte;
    form_t two_byte;
  } form_lookup_t;

  // One decoded result from the step logic
  typedef struct packed {
    logic       emit;
    logic [3:0] length;
    status_e    status;
    logic [7:0] opcode;
    logic       escape;
    logic [2:0] reg_field;
    logic       wide;
  } step_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/x64ild_in_if.sv -----
// ----------------------------------------------------------------------------
// x64ild_in_if
// Code byte channel: one stream byte per beat with an end-of-stream mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface x64ild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/x64ild_out_if.sv -----
// ----------------------------------------------------------------------------
// x64ild_out_if
// Result channel: one decoded instruction or error status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface x64ild_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] instr_length;
  logic [1:0] status;
  logic [7:0] opcode_value;
  logic       escape_0f;
  logic [2:0] modrm_reg_field;
  logic       wide_operand;

  modport source (
    output valid, output instr_length, output status, output opcode_value,
    output escape_0f, output modrm_reg_field, output wide_operand, input ready
  );
  modport sink (
    input valid, input instr_length, input status, input opcode_value,
    input escape_0f, input modrm_reg_field, input wide_operand, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/x64ild_form.sv -----
// ----------------------------------------------------------------------------
// x64ild_form
// Opcode form tables for the one-byte and the 0F two-byte map.
// ----------------------------------------------------------------------------
`default_nettype none

module x64ild_form
  import x64ild_pkg::*;
(
  input  logic [7:0]   code_byte_i,
  output form_lookup_t form_o
);

  form_t one_form;
  form_t two_form;

  // One-byte map
  always_comb begin
    case (code_byte_i) inside
      [8'h00:8'h3F]: begin
        case (code_byte_i[2:0]) inside
          [3'd0:3'd3]: one_form = FormModrm;
          3'd4:        one_form = FormImm8;
          3'd5:        one_form = FormImmz;
          default:     one_form = '0;
        endcase
      end
      [8'h50:8'h5F]: one_form = FormNone;
      [8'h70:8'h7F]: one_form = FormRel8;
      [8'h84:8'h8B]: one_form = FormModrm;
      [8'hB0:8'hB7]: one_form = FormImm8;
      [8'hB8:8'hBF]: one_form = FormImm64;
      [8'hD0:8'hD3]: one_form = FormModrm;
      8'h63, 8'h8D, 8'h8F, 8'hF6, 8'hF7, 8'hFE, 8'hFF:
        one_form = FormModrm;
      8'h68, 8'hA9: one_form = FormImmz;
      8'h6A, 8'hA8: one_form = FormImm8;
      8'h69, 8'h81, 8'hC7: one_form = FormModrm | FormImmz;
      8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6:
        one_form = FormModrm | FormImm8;
      8'h90, 8'h98, 8'h99, 8'h9C, 8'h9D, 8'hC3,
      8'hC9, 8'hCC, 8'hCF, 8'hF4, 8'hFA, 8'hFB:
        one_form = FormNone;
      8'hC2:        one_form = FormImm16;
      8'hE8, 8'hE9: one_form = FormRel32;
      8'hEB:        one_form = FormRel8;
      default:      one_form = '0;
    endcase
  end

  // Two-byte map, after the escape
  always_comb begin
    case (code_byte_i) inside
      [8'h40:8'h49], [8'h4C:8'h4F]: two_form = FormModrm;
      [8'h80:8'h8F]:                two_form = FormRel32;
      [8'h90:8'h99], [8'h9C:8'h9F]: two_form = FormModrm;
      8'h05, 8'h07, 8'h0B, 8'h30, 8'h31, 8'h32, 8'hA2:
        two_form = FormNone;
      8'h1E, 8'h1F, 8'h20, 8'h22, 8'h23,
      8'hA3, 8'hAB, 8'hAF, 8'hB0, 8'hB1, 8'hB3,
      8'hB6, 8'hB7, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
      8'hBF, 8'hC0, 8'hC1, 8'hC7:
        two_form = FormModrm;
      8'hBA:   two_form = FormModrm | FormImm8;
      default: two_form = '0;
    endcase
  end

  // Pack both lookups, one-byte map in the upper half
  assign form_o = {one_form, two_form};

endmodule

`default_nettype wire

// ----- rtl/core/x64ild_core.sv -----
// ----------------------------------------------------------------------------
// x64ild_core
// Per-byte decode step: prefix scan, opcode, ModRM, SIB and byte skipping.
// ----------------------------------------------------------------------------
`default_nettype none

`include "x86_64_instruction_length_decoder_assert.svh"

module x64ild_core
  import x64ild_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   code_byte_i,
  input  logic         last_byte_i,
  output step_result_t result_o
);

  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhOpcode = 3'd1,
    PhEsc    = 3'd2,
    PhModrm  = 3'd3,
    PhSib    = 3'd4,
    PhSkip   = 3'd5
  } phase_e;

  // Immediate and relative byte count of a form
  function automatic logic [3:0] imm_len(form_t f, logic wide, logic op16);
    logic [3:0] zsz;
    logic [3:0] n;
    zsz = (!wide && op16) ? 4'd2 : 4'd4;
    n   = 4'd0;
    if ((f & FormImm8)  != '0) n = n + 4'd1;
    if ((f & FormImm16) != '0) n = n + 4'd2;
    if ((f & FormImmz)  != '0) n = n + zsz;
    if ((f & FormImm64) != '0) n = n + (wide ? 4'd8 : (op16 ? 4'd2 : 4'd4));
    if ((f & FormRel8)  != '0) n = n + 4'd1;
    if ((f & FormRel32) != '0) n = n + zsz;
    if ((f & FormMoffs) != '0) n = n + 4'd8;
    return n;
  endfunction

  phase_e       phase_q, phase_d;
  logic [3:0]   seen_q, seen_d;
  logic [3:0]   skip_q, skip_d;
  logic         op16_q, op16_d;
  logic         wide_q, wide_d;
  form_t        form_q, form_d;
  logic [7:0]   opcode_q, opcode_d;
  logic         escape_q, escape_d;
  logic [2:0]   reg_q, reg_d;

  form_lookup_t lookup;
  logic [3:0]   seen_inc;
  logic         take_op;
  form_t        op_form;
  logic [3:0]   op_imm;
  form_t        modrm_form;
  logic [3:0]   modrm_imm;
  logic [3:0]   modrm_disp;
  logic [3:0]   sib_imm;
  logic [3:0]   sib_disp;
  logic         grp3_imm;
  logic         advance;
  logic         unknown;
  logic [3:0]   need;
  phase_e       adv_phase;
  logic         emit;
  status_e      status;

  x64ild_form u_form (
    .code_byte_i (code_byte_i),
    .form_o      (lookup)
  );

  assign seen_inc = seen_q + 4'd1;

  // Opcode path, shared by both maps
  assign op_form = (phase_q == PhEsc) ? lookup.two_byte : lookup.one_byte;
  assign op_imm  = imm_len(op_form, wide_q, op16_q);

  // ModRM path, with the group 3 test immediate folded in
  assign grp3_imm = !escape_q && ((opcode_q == ByteGrp3B) || (opcode_q == ByteGrp3V))
                    && (code_byte_i[5:3] <= 3'd1);
  assign modrm_form = grp3_imm ? (form_q | ((opcode_q == ByteGrp3B) ? FormImm8 : FormImmz))
                               : form_q;
  assign modrm_imm  = imm_len(modrm_form, wide_q, op16_q);
  assign modrm_disp = (code_byte_i[7:6] == 2'd1) ? 4'd1 :
                      (code_byte_i[7:6] == 2'd2) ? 4'd4 : 4'd0;

  // SIB path: a base of 5 under mod 0 brings a 32-bit displacement
  assign sib_imm  = imm_len(form_q, wide_q, op16_q);
  assign sib_disp = ((skip_q == 4'd0) && (code_byte_i[2:0] == 3'd5)) ? 4'd4 : skip_q;

  // Next state and result for the byte in hand
  always_comb begin
    phase_d   = phase_q;
    seen_d    = seen_inc;
    skip_d    = skip_q;
    op16_d    = op16_q;
    wide_d    = wide_q;
    form_d    = form_q;
    opcode_d  = opcode_q;
    escape_d  = escape_q;
    reg_d     = reg_q;
    take_op   = 1'b0;
    advance   = 1'b0;
    unknown   = 1'b0;
    need      = 4'd0;
    adv_phase = PhPrefix;
    emit      = 1'b0;
    status    = StOk;

    case (phase_q)
      PhEsc: begin
        take_op = 1'b1;
      end
      PhModrm: begin
        reg_d   = code_byte_i[5:3];
        form_d  = modrm_form;
        advance = 1'b1;
        if ((code_byte_i[7:6] != 2'd3) && (code_byte_i[2:0] == 3'd4)) begin
          skip_d    = modrm_disp;
          need      = 4'd1 + modrm_disp + modrm_imm;
          adv_phase = PhSib;
        end else if ((code_byte_i[7:6] == 2'd0) && (code_byte_i[2:0] == 3'd5)) begin
          skip_d    = 4'd4 + modrm_imm;
          need      = 4'd4 + modrm_imm;
          adv_phase = PhSkip;
        end else begin
          skip_d    = modrm_disp + modrm_imm;
          need      = modrm_disp + modrm_imm;
          adv_phase = PhSkip;
        end
      end
      PhSib: begin
        skip_d    = sib_disp + sib_imm;
        need      = sib_disp + sib_imm;
        advance   = 1'b1;
        adv_phase = PhSkip;
      end
      PhSkip: begin
        skip_d    = (skip_q != 4'd0) ? skip_q - 4'd1 : 4'd0;
        need      = skip_d;
        advance   = 1'b1;
        adv_phase = PhSkip;
      end
      PhOpcode: begin
        if (code_byte_i == ByteEscape) begin
          escape_d  = 1'b1;
          opcode_d  = ByteEscape;
          need      = 4'd1;
          advance   = 1'b1;
          adv_phase = PhEsc;
        end else begin
          take_op = 1'b1;
        end
      end
      default: begin
        case (code_byte_i) inside
          8'h66, 8'hF3, 8'h67, 8'hF0, 8'hF2, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65:
          begin
            if (code_byte_i == ByteOpsize) op16_d = 1'b1;
            need      = 4'd1;
            advance   = 1'b1;
            adv_phase = PhPrefix;
          end
          default: begin
            if (code_byte_i[7:4] == RexHigh) begin
              wide_d    = code_byte_i[3];
              need      = 4'd1;
              advance   = 1'b1;
              adv_phase = PhOpcode;
            end else if (code_byte_i == ByteEscape) begin
              escape_d  = 1'b1;
              opcode_d  = ByteEscape;
              need      = 4'd1;
              advance   = 1'b1;
              adv_phase = PhEsc;
            end else begin
              take_op = 1'b1;
            end
          end
        endcase
      end
    endcase

    // Classify the opcode byte
    if (take_op) begin
      opcode_d = code_byte_i;
      if (op_form == '0) begin
        unknown = 1'b1;
      end else begin
        form_d  = op_form;
        advance = 1'b1;
        if ((op_form & FormModrm) != '0) begin
          need      = 4'd1 + op_imm;
          adv_phase = PhModrm;
        end else begin
          skip_d    = op_imm;
          need      = op_imm;
          adv_phase = PhSkip;
        end
      end
    end

    // Finish the instruction or move on; overflow wins over truncation
    if (unknown) begin
      emit   = 1'b1;
      status = StUnknown;
    end else if (advance) begin
      if (({1'b0, seen_inc} + {1'b0, need}) > MaxLength) begin
        emit   = 1'b1;
        status = StTooLong;
      end else if (need == 4'd0) begin
        emit   = 1'b1;
        status = StOk;
      end else if (last_byte_i) begin
        emit   = 1'b1;
        status = StTruncated;
      end else begin
        phase_d = adv_phase;
      end
    end

    result_o.emit      = emit;
    result_o.length    = (status == StOk) ? seen_inc : 4'd0;
    result_o.status    = status;
    result_o.opcode    = opcode_d;
    result_o.escape    = escape_d;
    result_o.reg_field = reg_d;
    result_o.wide      = wide_d;

    // Restart at a new instruction after any result
    if (emit) begin
      phase_d  = PhPrefix;
      seen_d   = 4'd0;
      skip_d   = 4'd0;
      op16_d   = 1'b0;
      wide_d   = 1'b0;
      form_d   = '0;
      opcode_d = 8'h00;
      escape_d = 1'b0;
      reg_d    = 3'd0;
    end
  end

  // Hold decode state; advance one byte per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhPrefix;
      seen_q   <= 4'd0;
      skip_q   <= 4'd0;
      op16_q   <= 1'b0;
      wide_q   <= 1'b0;
      form_q   <= '0;
      opcode_q <= 8'h00;
      escape_q <= 1'b0;
      reg_q    <= 3'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      skip_q   <= skip_d;
      op16_q   <= op16_d;
      wide_q   <= wide_d;
      form_q   <= form_d;
      opcode_q <= opcode_d;
      escape_q <= escape_d;
      reg_q    <= reg_d;
    end
  end

  `X64ILD_ASSERT_CLK(a_skip_pending, (phase_q == PhSkip) |-> (skip_q != 4'd0), "skip phase with nothing left to skip")
  `X64ILD_ASSERT_CLK(a_sib_disp, (phase_q == PhSib) |-> ((skip_q == 4'd0) || (skip_q == 4'd1) || (skip_q == 4'd4)), "SIB phase with a bad displacement size")
  `X64ILD_ASSERT_NEVER(a_seen_bound, seen_q == 4'd15, "open instruction already at fifteen bytes")

endmodule

`default_nettype wire

// ----- rtl/core/x86_64_instruction_length_decoder.sv -----
// Bytes pass the input register and the decode step; any result waits in the result register.
// One byte per cycle unless a result stalls; the input register refills while it waits.
// A stalled result register holds the decode step and, once the input register is full, the input.
// Reset (rst_ni low, asynchronous) empties both registers and restarts at a prefix scan.
// ----------------------------------------------------------------------------
// x86_64_instruction_length_decoder
// Finds instruction boundaries in a byte stream and reports length or error.
// ----------------------------------------------------------------------------
`default_nettype none

`include "x86_64_instruction_length_decoder_assert.svh"

module x86_64_instruction_length_decoder
  import x64ild_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  x64ild_in_if.sink     in_i,
  x64ild_out_if.source  out_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  step_result_t out_res_q;
  step_result_t step_res;
  logic         step_en;
  logic         in_fire;

  // Step when a byte waits and the result slot is free or draining
  assign step_en    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_en;
  assign in_fire    = in_i.valid && in_i.ready;

  x64ild_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_en),
    .code_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (step_res)
  );

  // Track input and result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end
      if (step_en && step_res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input beat and the finished result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_i.code_byte;
      in_last_q <= in_i.last_byte;
    end
    if (step_en && step_res.emit) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.instr_length    = out_res_q.length;
  assign out_o.status          = out_res_q.status;
  assign out_o.opcode_value    = out_res_q.opcode;
  assign out_o.escape_0f       = out_res_q.escape;
  assign out_o.modrm_reg_field = out_res_q.reg_field;
  assign out_o.wide_operand    = out_res_q.wide;

  `X64ILD_ASSERT_CLK(a_err_len_zero, (out_o.valid && (out_o.status != StOk)) |-> (out_o.instr_length == 4'd0), "error result with a length")
  `X64ILD_ASSERT_CLK(a_ok_len_set, (out_o.valid && (out_o.status == StOk)) |-> (out_o.instr_length != 4'd0), "good result with zero length")
  `X64ILD_ASSERT_CLK(a_ready_blocked, !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready), "input stalled without a full result stall")

endmodule

`default_nettype wire

// ----- sim/x86_64_instruction_length_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_64_instruction_length_decoder_tb
// Feeds a byte stream into the length decoder and checks every result beat
// against a cycle-free decode model kept in step with the accepted bytes.
// The stream starts with hand-picked instructions, then mostly well-formed
// random instructions mixed with noise and early end-of-stream marks. Both
// sides idle at random, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module x86_64_instruction_length_decoder_tb
  import x64ild_pkg::*;
;

  localparam int RandomItems    = 1625;
  localparam int CalmTailItems  = 250;
  localparam int LongHoldCycles = 120;
  localparam int SettleCycles   = 8;
  localparam int DrainLimit     = 4000;

  // ModRM and SIB field codes with a special meaning
  localparam logic [1:0] ModNoDisp = 2'd0;
  localparam logic [1:0] ModDisp8  = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;
  localparam logic [1:0] ModReg    = 2'd3;
  localparam logic [2:0] RmSib     = 3'd4;
  localparam logic [2:0] RmDisp32  = 3'd5;

  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhOpcode = 3'd1,
    PhEsc    = 3'd2,
    PhModrm  = 3'd3,
    PhSib    = 3'd4,
    PhSkip   = 3'd5
  } scan_phase_e;

  typedef struct {
    logic [7:0]   code;
    logic         last;
    bit           fixed;
    step_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  x64ild_in_if  in_if ();
  x64ild_out_if out_if ();

  x86_64_instruction_length_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decode model state
  scan_phase_e dec_phase;
  logic [3:0]  seen_cnt;
  logic [3:0]  skip_cnt;
  logic        op_short;
  logic        rex_w;
  form_t       pend_form;
  logic [7:0]  held_op;
  logic        held_esc;
  logic [2:0]  held_reg;

  step_result_t instr_results_q[$];
  stim_row_t    dir_rows[$];
  int           fail_cnt = 0;
  int           bytes_fed = 0;
  int           status_tally[4] = '{0, 0, 0, 0};
  bit           idle_en = 1'b1;
  bit           hold_off_req = 1'b0;
  bit           prefix_storm = 1'b0;

  // Clock and reset
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------
  function automatic form_t one_byte_form(logic [7:0] b);
    if (b < 8'h40) begin
      case (b[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: return FormModrm;
        3'd4:                   return FormImm8;
        3'd5:                   return FormImmz;
        default:                return '0;
      endcase
    end
    if (b >= 8'h50 && b <= 8'h5F) return FormNone;
    if (b >= 8'h70 && b <= 8'h7F) return FormRel8;
    if (b >= 8'h84 && b <= 8'h8B) return FormModrm;
    if (b >= 8'hB0 && b <= 8'hB7) return FormImm8;
    if (b >= 8'hB8 && b <= 8'hBF) return FormImm64;
    if (b >= 8'hD0 && b <= 8'hD3) return FormModrm;
    case (b)
      8'h63, 8'h8D, 8'h8F, 8'hF6, 8'hF7, 8'hFE, 8'hFF: return FormModrm;
      8'h68, 8'hA9:                                     return FormImmz;
      8'h6A, 8'hA8:                                     return FormImm8;
      8'h69, 8'h81, 8'hC7:                              return FormModrm | FormImmz;
      8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6:         return FormModrm | FormImm8;
      8'h90, 8'h98, 8'h99, 8'h9C, 8'h9D, 8'hC3,
      8'hC9, 8'hCC, 8'hCF, 8'hF4, 8'hFA, 8'hFB:         return FormNone;
      8'hC2:                                            return FormImm16;
      8'hE8, 8'hE9:                                     return FormRel32;
      8'hEB:                                            return FormRel8;
      default:                                          return '0;
    endcase
  endfunction

  function automatic form_t two_byte_form(logic [7:0] b);
    if (b >= 8'h40 && b <= 8'h4F && b != 8'h4A && b != 8'h4B) return FormModrm;
    if (b >= 8'h80 && b <= 8'h8F) return FormRel32;
    if (b >= 8'h90 && b <= 8'h9F && b != 8'h9A && b != 8'h9B) return FormModrm;
    case (b)
      8'h05, 8'h07, 8'h0B, 8'h30, 8'h31, 8'h32, 8'hA2: return FormNone;
      8'h1E, 8'h1F, 8'h20, 8'h22, 8'h23, 8'hA3, 8'hAB, 8'hAF,
      8'hB0, 8'hB1, 8'hB3, 8'hB6, 8'hB7, 8'hBB, 8'hBC, 8'hBD,
      8'hBE, 8'hBF, 8'hC0, 8'hC1, 8'hC7:               return FormModrm;
      8'hBA:                                           return FormModrm | FormImm8;
      default:                                         return '0;
    endcase
  endfunction

  function automatic bit is_legacy_prefix(logic [7:0] b);
    case (b)
      8'h66, 8'hF3, 8'h67, 8'hF0, 8'hF2, 8'h2E,
      8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: return 1'b1;
      default:                           return 1'b0;
    endcase
  endfunction

  // Immediate and relative bytes that a form still owes
  function automatic int imm_bytes(form_t f);
    int sz;
    int zsz;
    int n;
    sz  = rex_w ? 8 : (op_short ? 2 : 4);
    zsz = (sz == 2) ? 2 : 4;
    n   = 0;
    if (|(f & FormImm8))  n += 1;
    if (|(f & FormImm16)) n += 2;
    if (|(f & FormImmz))  n += zsz;
    if (|(f & FormImm64)) n += sz;
    if (|(f & FormRel8))  n += 1;
    if (|(f & FormRel32)) n += zsz;
    if (|(f & FormMoffs)) n += 8;
    return n;
  endfunction

  function automatic void start_instr();
    dec_phase = PhPrefix;
    seen_cnt  = '0;
    skip_cnt  = '0;
    op_short  = 1'b0;
    rex_w     = 1'b0;
    pend_form = '0;
    held_op   = '0;
    held_esc  = 1'b0;
    held_reg  = '0;
  endfunction

  function automatic step_result_t finish_instr(status_e st);
    step_result_t r;
    r.emit      = 1'b1;
    r.length    = (st == StOk) ? seen_cnt : 4'd0;
    r.status    = st;
    r.opcode    = held_op;
    r.escape    = held_esc;
    r.reg_field = held_reg;
    r.wide      = rex_w;
    start_instr();
    return r;
  endfunction

  // Close the instruction if it is too long, complete or cut off; else advance
  function automatic step_result_t move_on(int need, scan_phase_e nxt, logic last);
    step_result_t r;
    r = '0;
    if (int'(seen_cnt) + need > int'(MaxLength)) return finish_instr(StTooLong);
    if (need == 0) return finish_instr(StOk);
    if (last) return finish_instr(StTruncated);
    dec_phase = nxt;
    return r;
  endfunction

  function automatic step_result_t take_opcode(logic [7:0] b, logic esc, logic last);
    form_t f;
    f       = esc ? two_byte_form(b) : one_byte_form(b);
    held_op = b;
    if (f == '0) return finish_instr(StUnknown);
    pend_form = f;
    if (|(f & FormModrm)) return move_on(1 + imm_bytes(f), PhModrm, last);
    skip_cnt = 4'(imm_bytes(f));
    return move_on(int'(skip_cnt), PhSkip, last);
  endfunction

  // Advance the model by one code byte; emit is set when a result is due
  function automatic step_result_t decode_byte(logic [7:0] b, logic last);
    logic [1:0] mod_f;
    logic [2:0] rm_f;
    int         disp;
    form_t      f;
    seen_cnt = seen_cnt + 4'd1;
    case (dec_phase)
      PhEsc: return take_opcode(b, 1'b1, last);
      PhModrm: begin
        mod_f    = b[7:6];
        rm_f     = b[2:0];
        held_reg = b[5:3];
        f        = pend_form;
        // test group: TEST forms carry an immediate
        if (!held_esc && (held_op == ByteGrp3B || held_op == ByteGrp3V) && held_reg <= 3'd1)
          f = f | ((held_op == ByteGrp3B) ? FormImm8 : FormImmz);
        pend_form = f;
        disp = (mod_f == ModDisp8) ? 1 : ((mod_f == ModDisp32) ? 4 : 0);
        if (mod_f != ModReg && rm_f == RmSib) begin
          skip_cnt = 4'(disp);
          return move_on(1 + disp + imm_bytes(f), PhSib, last);
        end
        if (mod_f == ModNoDisp && rm_f == RmDisp32) disp = 4;
        skip_cnt = 4'(disp + imm_bytes(f));
        return move_on(int'(skip_cnt), PhSkip, last);
      end
      PhSib: begin
        // held displacement is zero exactly when mod was zero
        disp = int'(skip_cnt);
        if (disp == 0 && b[2:0] == RmDisp32) disp = 4;
        skip_cnt = 4'(disp + imm_bytes(pend_form));
        return move_on(int'(skip_cnt), PhSkip, last);
      end
      PhSkip: begin
        if (skip_cnt != '0) skip_cnt = skip_cnt - 4'd1;
        return move_on(int'(skip_cnt), PhSkip, last);
      end
      default: begin
        // prefix scan and the opcode slot after a REX byte
        if (dec_phase != PhOpcode && is_legacy_prefix(b)) begin
          if (b == ByteOpsize) op_short = 1'b1;
          return move_on(1, PhPrefix, last);
        end
        if (dec_phase != PhOpcode && b[7:4] == RexHigh) begin
          rex_w = b[3];
          return move_on(1, PhOpcode, last);
        end
        if (b == ByteEscape) begin
          held_esc = 1'b1;
          held_op  = ByteEscape;
          return move_on(1, PhEsc, last);
        end
        return take_opcode(b, 1'b0, last);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t plain(logic [7:0] b, logic l);
    stim_row_t s;
    s.code  = b;
    s.last  = l;
    s.fixed = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  function automatic stim_row_t pinned(logic [7:0] b, logic l, logic [3:0] len, status_e st,
                                       logic [7:0] op, logic esc, logic [2:0] rg, logic w);
    stim_row_t s;
    s.code  = b;
    s.last  = l;
    s.fixed = 1'b1;
    s.res   = '{emit: 1'b1, length: len, status: st, opcode: op, escape: esc,
                reg_field: rg, wide: w};
    return s;
  endfunction

  function automatic logic [7:0] valid_opcode(bit two_map);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((two_map ? two_byte_form(b) : one_byte_form(b)) == '0);
    return b;
  endfunction

  // Pick the next byte to suit the instruction being built
  function automatic logic [7:0] next_code_byte();
    logic [7:0] b;
    int         roll;
    roll = $urandom_range(0, 99);
    if (dec_phase == PhPrefix && seen_cnt == '0) prefix_storm = ($urandom_range(0, 24) == 0);
    if (roll < 5) return 8'($urandom_range(0, 255));
    case (dec_phase)
      PhPrefix: begin
        if (roll < (prefix_storm ? 95 : 25)) begin
          if ($urandom_range(0, 1)) return ByteOpsize;
          do b = 8'($urandom_range(0, 255)); while (!is_legacy_prefix(b));
          return b;
        end
        if (prefix_storm) return valid_opcode(1'b0);
        if (roll < 40) return {RexHigh, 4'($urandom_range(0, 15))};
        if (roll < 50) return ByteEscape;
        if (roll < 58) return $urandom_range(0, 1) ? ByteGrp3B : ByteGrp3V;
        if (roll < 92) return valid_opcode(1'b0);
        return 8'($urandom_range(0, 255));
      end
      PhOpcode: begin
        if (roll < 15) return ByteEscape;
        if (roll < 22) return $urandom_range(0, 1) ? ByteGrp3B : ByteGrp3V;
        if (roll < 90) return valid_opcode(1'b0);
        return 8'($urandom_range(0, 255));
      end
      PhEsc: begin
        if (roll < 85) return valid_opcode(1'b1);
        return 8'($urandom_range(0, 255));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte, hold it until taken, then log the expected decode
  task automatic send_beat(input logic [7:0] b, input logic l, input bit fixed,
                           input step_result_t fixed_res);
    step_result_t r;
    in_if.valid     <= 1'b1;
    in_if.code_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    bytes_fed++;
    r = decode_byte(b, l);
    if (fixed) r = fixed_res;
    if (r.emit) begin
      instr_results_q.push_back(r);
      status_tally[r.status]++;
    end
    // random gap before the next beat
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  initial begin : code_source
    logic [7:0] cb;
    stim_row_t  row;
    in_if.valid     <= 1'b0;
    in_if.code_byte <= '0;
    in_if.last_byte <= 1'b0;
    start_instr();

    // hand-picked instructions
    dir_rows.push_back(pinned(8'h90, 1'b0, 4'd1, StOk, 8'h90, 1'b0, 3'd0, 1'b0));
    dir_rows.push_back(plain(8'h00, 1'b0));
    dir_rows.push_back(pinned(8'hC0, 1'b0, 4'd2, StOk, 8'h00, 1'b0, 3'd0, 1'b0));
    dir_rows.push_back(plain(8'hFF, 1'b0));
    dir_rows.push_back(pinned(8'hFF, 1'b0, 4'd2, StOk, 8'hFF, 1'b0, 3'd7, 1'b0));
    // unknown opcode wins over the end mark
    dir_rows.push_back(pinned(8'h06, 1'b1, 4'd0, StUnknown, 8'h06, 1'b0, 3'd0, 1'b0));
    // prefix after REX counts as an unknown opcode
    dir_rows.push_back(plain(8'h48, 1'b0));
    dir_rows.push_back(pinned(ByteOpsize, 1'b0, 4'd0, StUnknown, ByteOpsize, 1'b0, 3'd0,
                              1'b1));
    // call cut off by the end mark
    dir_rows.push_back(pinned(8'hE8, 1'b1, 4'd0, StTruncated, 8'hE8, 1'b0, 3'd0, 1'b0));
    // four prefixes, REX.W, mov with SIB, disp32 and imm32: over fifteen bytes
    dir_rows.push_back(plain(8'h2E, 1'b0));
    dir_rows.push_back(plain(8'h36, 1'b0));
    dir_rows.push_back(plain(8'h3E, 1'b0));
    dir_rows.push_back(plain(8'h26, 1'b0));
    dir_rows.push_back(plain(8'h48, 1'b0));
    dir_rows.push_back(plain(8'hC7, 1'b0));
    dir_rows.push_back(pinned(8'h84, 1'b0, 4'd0, StTooLong, 8'hC7, 1'b0, 3'd0, 1'b1));
    // rep ahead of a two-byte bit scan
    dir_rows.push_back(plain(8'hF3, 1'b0));
    dir_rows.push_back(plain(ByteEscape, 1'b0));
    dir_rows.push_back(plain(8'hBC, 1'b0));
    dir_rows.push_back(plain(8'hC0, 1'b0));
    // test with imm8 through the group rule
    dir_rows.push_back(plain(ByteGrp3B, 1'b0));
    dir_rows.push_back(plain(8'hC0, 1'b0));
    dir_rows.push_back(plain(8'h11, 1'b0));
    // ret imm16 ending exactly on the end mark
    dir_rows.push_back(plain(8'hC2, 1'b0));
    dir_rows.push_back(plain(8'h34, 1'b0));
    dir_rows.push_back(plain(8'h12, 1'b1));
    // complete one-byte instruction on the end mark
    dir_rows.push_back(pinned(8'hF4, 1'b1, 4'd1, StOk, 8'hF4, 1'b0, 3'd0, 1'b0));

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.code, row.last, row.fixed, row.res);
    end

    // random instructions, segments with and without idling, calm tail
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 200 == 0)
        idle_en = (i < RandomItems - CalmTailItems) && ($urandom_range(0, 3) != 0);
      if (i == 400) hold_off_req = 1'b1;
      cb = next_code_byte();
      send_beat(cb, $urandom_range(0, 49) == 0, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    // drain what is still owed, then settle
    for (int k = 0; k < DrainLimit && instr_results_q.size() != 0; k++) @(posedge clk_i);
    if (instr_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, instr_results_q.size());
      fail_cnt++;
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("Fed %0d code bytes; results ok %0d, unknown %0d, truncated %0d, too long %0d.",
             bytes_fed, status_tally[StOk], status_tally[StUnknown],
             status_tally[StTruncated], status_tally[StTooLong]);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random ready bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int span;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        span = LongHoldCycles;
      end else if (!idle_en || $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b1;
        span = $urandom_range(1, 24);
      end else begin
        out_if.ready <= 1'b0;
        span = $urandom_range(1, 9);
      end
      repeat (span - 1) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    step_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (instr_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual len %0h status %0h op %0h",
                 $time, out_if.instr_length, out_if.status, out_if.opcode_value);
        fail_cnt++;
      end else begin
        want = instr_results_q.pop_front();
        check_field("instr_length", 8'(want.length), 8'(out_if.instr_length));
        check_field("status", 8'(want.status), 8'(out_if.status));
        check_field("opcode_value", want.opcode, out_if.opcode_value);
        check_field("escape_0f", 8'(want.escape), 8'(out_if.escape_0f));
        check_field("modrm_reg_field", 8'(want.reg_field), 8'(out_if.modrm_reg_field));
        check_field("wide_operand", 8'(want.wide), 8'(out_if.wide_operand));
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("TB_ERROR");
    $finish;
  end

endmodule
